// ===== sv/wu_antialiased_line_rasterizer_core_macros.svh =====
// Assertion helpers used by the rasterizer controller.
// Both expect clk and rst_n in scope.
`ifndef WU_ANTIALIASED_LINE_RASTERIZER_CORE_MACROS_SVH
`define WU_ANTIALIASED_LINE_RASTERIZER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WAL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wal: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define WAL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wal: next-cycle check failed");

`endif

// ===== sv/wal_pkg.sv =====
package wal_pkg;

    localparam int CFG_BITS       = 12;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_VIEW_COLS = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VIEW_ROWS = 1'b1;

    localparam logic [CFG_BITS-1:0] VIEW_COLS_RESET = 12'd640;
    localparam logic [CFG_BITS-1:0] VIEW_ROWS_RESET = 12'd480;

    typedef enum logic [2:0] {
        KIND_POINT,
        KIND_HORIZ,
        KIND_VERT,
        KIND_DIAG,
        KIND_YMAJ,
        KIND_XMAJ
    } line_kind_t;

    // Which pixel goes into the output register this cycle.
    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_FIRST,
        EMIT_STEP,
        EMIT_PAIR
    } emit_sel_t;

    typedef struct packed {
        logic      load_in;
        logic      setup;
        logic      div_step;
        emit_sel_t emit;
    } wal_cmd_t;

    typedef struct packed {
        logic mode;
        logic setup_major;
        logic line_active;
        logic pair;
        logic out_free;
    } wal_status_t;

endpackage

// ===== sv/wal_ctrl.sv =====
`include "wu_antialiased_line_rasterizer_core_macros.svh"

module wal_ctrl #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  wal_pkg::wal_status_t status,
    output wal_pkg::wal_cmd_t    cmd
);
    import wal_pkg::*;

    localparam int CNT_W = $clog2(FRACTION_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_FIRST,
        S_STEP,
        S_PAIR
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] div_count_reg, div_count_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.emit       = EMIT_NONE;
        state_next     = state_reg;
        div_count_next = div_count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!status.mode)
                begin
                    cmd.setup      = 1'b1;
                    state_next     = status.setup_major ? S_DIV : S_FIRST;
                    div_count_next = CNT_W'(FRACTION_BITS - 1);
                end
                else
                begin
                    // advance with no line in progress gives nothing
                    state_next = status.line_active ? S_STEP : S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_count_reg == '0)
                    state_next = S_FIRST;
                else
                    div_count_next = div_count_reg - CNT_W'(1);
            end
            S_FIRST:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = EMIT_FIRST;
                    state_next = S_IDLE;
                end
            end
            S_STEP:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = EMIT_STEP;
                    state_next = status.pair ? S_PAIR : S_IDLE;
                end
            end
            S_PAIR:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = EMIT_PAIR;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            div_count_reg <= div_count_next;
        end
    end

    `WAL_ASSERT_SAME(a_emit_only_when_free, cmd.emit != EMIT_NONE, status.out_free)
    `WAL_ASSERT_NEXT(a_div_ends_in_first, state_reg == S_DIV && div_count_reg == '0, state_reg == S_FIRST)
    `WAL_ASSERT_NEXT(a_accept_goes_to_decode, in_valid && !in_stall, state_reg == S_DECODE)
    `WAL_ASSERT_SAME(a_pair_follows_step, state_reg == S_PAIR, $past(state_reg) == S_STEP || $past(state_reg) == S_PAIR)

endmodule

// ===== sv/wal_dp.sv =====
module wal_dp #(
    parameter int COORD_BITS    = 12,
    parameter int FRACTION_BITS = 16,
    parameter int WEIGHT_BITS   = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  wal_pkg::wal_cmd_t                      cmd,
    output wal_pkg::wal_status_t                   status,
    input  logic                                   cfg_write,
    input  logic [wal_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [wal_pkg::CFG_BITS-1:0]           cfg_data,
    input  logic                                   mode,
    input  logic signed [COORD_BITS-1:0]           x_start,
    input  logic signed [COORD_BITS-1:0]           y_start,
    input  logic signed [COORD_BITS-1:0]           x_end,
    input  logic signed [COORD_BITS-1:0]           y_end,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [COORD_BITS:0]             pixel_x,
    output logic signed [COORD_BITS:0]             pixel_y,
    output logic [WEIGHT_BITS-1:0]                 background_weight,
    output logic                                   on_screen,
    output logic                                   line_done
);
    import wal_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int P  = COORD_BITS + 1;
    localparam int F  = FRACTION_BITS;
    localparam int W  = WEIGHT_BITS;
    localparam int CW = (P > CFG_BITS) ? P : CFG_BITS;

    // configuration
    logic [CFG_BITS-1:0] view_cols_reg, view_rows_reg;

    // input item
    logic                mode_reg;
    logic signed [C-1:0] xs_reg, ys_reg, xe_reg, ye_reg;

    // line state
    logic signed [P-1:0] cur_x_reg, cur_y_reg, final_x_reg, final_y_reg;
    logic                step_left_reg;
    logic [C-1:0]        remaining_reg;
    logic [F-1:0]        error_step_reg, error_sum_reg;
    line_kind_t          line_kind_reg;
    logic                line_active_reg, endpoint_pending_reg;
    logic [C-1:0]        div_rem_reg, divisor_reg;

    // output register
    logic                out_valid_reg;
    logic signed [P-1:0] pixel_x_reg, pixel_y_reg;
    logic [W-1:0]        weight_reg;
    logic                on_screen_reg, line_done_reg;

    // ---------------- line setup ----------------
    logic                swap;
    logic signed [C-1:0] xa, ya, xb, yb;
    logic signed [P-1:0] dx_s, dy_s, adx_w;
    logic                left;
    logic [C-1:0]        adx, dy, major_len, minor_len, rem_init;
    line_kind_t          kind_init;
    logic                setup_major;

    always_comb
    begin
        swap  = ys_reg > ye_reg;
        xa    = swap ? xe_reg : xs_reg;
        ya    = swap ? ye_reg : ys_reg;
        xb    = swap ? xs_reg : xe_reg;
        yb    = swap ? ys_reg : ye_reg;
        dx_s  = P'(xb) - P'(xa);
        dy_s  = P'(yb) - P'(ya);
        left  = dx_s[P-1];
        adx_w = left ? -dx_s : dx_s;
        adx   = adx_w[C-1:0];
        dy    = dy_s[C-1:0];
        priority if (dy == '0)
            kind_init = (adx == '0) ? KIND_POINT : KIND_HORIZ;
        else if (adx == '0)
            kind_init = KIND_VERT;
        else if (adx == dy)
            kind_init = KIND_DIAG;
        else if (dy > adx)
            kind_init = KIND_YMAJ;
        else
            kind_init = KIND_XMAJ;
        setup_major = (kind_init == KIND_YMAJ) || (kind_init == KIND_XMAJ);
        major_len   = (kind_init == KIND_YMAJ) ? dy : adx;
        minor_len   = (kind_init == KIND_YMAJ) ? adx : dy;
        unique case (kind_init)
            KIND_POINT, KIND_HORIZ: rem_init = adx;
            KIND_VERT, KIND_DIAG:   rem_init = dy;
            default:                rem_init = major_len - C'(1);
        endcase
    end

    // ---------------- divider step (restoring, one bit a cycle) ----------------
    logic [P-1:0] div_shift, div_diff;
    logic         div_ge;

    always_comb
    begin
        div_shift = {div_rem_reg, 1'b0};
        div_ge    = div_shift >= {1'b0, divisor_reg};
        div_diff  = div_shift - {1'b0, divisor_reg};
    end

    // ---------------- advance step ----------------
    logic signed [P-1:0] x_fwd, y_up;
    logic                major, at_end, wrap;
    logic [F-1:0]        sum_add;
    logic [C-1:0]        rem_dec;
    logic signed [P-1:0] step_x, step_y, pair_x, pair_y;
    logic [W-1:0]        step_w;
    logic                step_done;
    logic [C-1:0]        rem_next;
    logic                active_next, pending_next;
    logic [F-1:0]        sum_next;

    always_comb
    begin
        x_fwd   = step_left_reg ? cur_x_reg - P'(1) : cur_x_reg + P'(1);
        y_up    = cur_y_reg + P'(1);
        major   = (line_kind_reg == KIND_YMAJ) || (line_kind_reg == KIND_XMAJ);
        at_end  = endpoint_pending_reg || (remaining_reg == '0);
        sum_add = error_sum_reg + error_step_reg;
        wrap    = sum_add <= error_sum_reg;
        rem_dec = remaining_reg - C'(1);

        step_x       = cur_x_reg;
        step_y       = cur_y_reg;
        step_w       = '0;
        step_done    = 1'b0;
        rem_next     = remaining_reg;
        active_next  = line_active_reg;
        pending_next = endpoint_pending_reg;
        sum_next     = error_sum_reg;

        if (major)
        begin
            if (at_end)
            begin
                step_x       = final_x_reg;
                step_y       = final_y_reg;
                step_done    = 1'b1;
                active_next  = 1'b0;
                pending_next = 1'b0;
            end
            else
            begin
                sum_next = sum_add;
                step_w   = sum_add[F-1 -: W];
                if (line_kind_reg == KIND_YMAJ)
                begin
                    step_x = wrap ? x_fwd : cur_x_reg;
                    step_y = y_up;
                end
                else
                begin
                    step_x = x_fwd;
                    step_y = wrap ? y_up : cur_y_reg;
                end
                rem_next     = rem_dec;
                pending_next = (rem_dec == '0);
            end
        end
        else
        begin
            unique case (line_kind_reg)
                KIND_HORIZ: step_x = x_fwd;
                KIND_VERT:  step_y = y_up;
                KIND_DIAG:
                begin
                    step_x = x_fwd;
                    step_y = y_up;
                end
                default:
                begin
                    step_x = cur_x_reg;
                end
            endcase
            rem_next    = (remaining_reg != '0) ? rem_dec : remaining_reg;
            active_next = (rem_next != '0);
            step_done   = (rem_next == '0);
        end

        // second pixel of a straddling pair, from the already stepped state
        pair_x = (line_kind_reg == KIND_YMAJ) ? x_fwd : cur_x_reg;
        pair_y = (line_kind_reg == KIND_YMAJ) ? cur_y_reg : y_up;
    end

    // ---------------- output select ----------------
    logic signed [P-1:0] sel_x, sel_y;
    logic [W-1:0]        sel_w;
    logic                sel_done, sel_vis;

    always_comb
    begin
        unique case (cmd.emit)
            EMIT_FIRST:
            begin
                sel_x    = cur_x_reg;
                sel_y    = cur_y_reg;
                sel_w    = '0;
                sel_done = (line_kind_reg == KIND_POINT);
            end
            EMIT_STEP:
            begin
                sel_x    = step_x;
                sel_y    = step_y;
                sel_w    = step_w;
                sel_done = step_done;
            end
            EMIT_PAIR:
            begin
                sel_x    = pair_x;
                sel_y    = pair_y;
                sel_w    = ~error_sum_reg[F-1 -: W];
                sel_done = 1'b0;
            end
            default:
            begin
                sel_x    = cur_x_reg;
                sel_y    = cur_y_reg;
                sel_w    = '0;
                sel_done = 1'b0;
            end
        endcase
        sel_vis = !sel_x[P-1] && !sel_y[P-1]
               && (CW'($unsigned(sel_x)) < CW'(view_cols_reg))
               && (CW'($unsigned(sel_y)) < CW'(view_rows_reg));
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_cols_reg        <= VIEW_COLS_RESET;
            view_rows_reg        <= VIEW_ROWS_RESET;
            line_kind_reg        <= KIND_POINT;
            line_active_reg      <= 1'b0;
            endpoint_pending_reg <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_VIEW_COLS: view_cols_reg <= cfg_data;
                    REG_VIEW_ROWS: view_rows_reg <= cfg_data;
                    default:       view_cols_reg <= view_cols_reg;
                endcase
            end
            if (cmd.setup)
            begin
                line_kind_reg        <= kind_init;
                line_active_reg      <= (kind_init != KIND_POINT);
                endpoint_pending_reg <= setup_major && (rem_init == '0);
            end
            else if (cmd.emit == EMIT_STEP)
            begin
                line_active_reg      <= active_next;
                endpoint_pending_reg <= pending_next;
            end
            if (cmd.emit != EMIT_NONE)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg <= mode;
            xs_reg   <= x_start;
            ys_reg   <= y_start;
            xe_reg   <= x_end;
            ye_reg   <= y_end;
        end
        if (cmd.setup)
        begin
            cur_x_reg      <= P'(xa);
            cur_y_reg      <= P'(ya);
            final_x_reg    <= P'(xb);
            final_y_reg    <= P'(yb);
            step_left_reg  <= left;
            remaining_reg  <= rem_init;
            error_sum_reg  <= '0;
            error_step_reg <= '0;
            div_rem_reg    <= minor_len;
            divisor_reg    <= major_len;
        end
        else if (cmd.div_step)
        begin
            div_rem_reg    <= div_ge ? div_diff[C-1:0] : div_shift[C-1:0];
            error_step_reg <= {error_step_reg[F-2:0], div_ge};
        end
        else if (cmd.emit == EMIT_STEP)
        begin
            cur_x_reg     <= step_x;
            cur_y_reg     <= step_y;
            remaining_reg <= rem_next;
            error_sum_reg <= sum_next;
        end
        if (cmd.emit != EMIT_NONE)
        begin
            pixel_x_reg   <= sel_x;
            pixel_y_reg   <= sel_y;
            weight_reg    <= sel_w;
            on_screen_reg <= sel_vis;
            line_done_reg <= sel_done;
        end
    end

    always_comb
    begin
        status.mode        = mode_reg;
        status.setup_major = setup_major;
        status.line_active = line_active_reg;
        status.pair        = major && !at_end;
        status.out_free    = !out_valid_reg || !out_stall;
    end

    assign out_valid         = out_valid_reg;
    assign pixel_x           = pixel_x_reg;
    assign pixel_y           = pixel_y_reg;
    assign background_weight = weight_reg;
    assign on_screen         = on_screen_reg;
    assign line_done         = line_done_reg;

endmodule

// ===== sv/wu_antialiased_line_rasterizer_core.sv =====
// Wu anti-aliased line generator.
// Input channel (in_valid/in_stall): mode 0 starts a line from the two endpoints,
// mode 1 advances it. Output channel (out_valid/out_stall): one pixel per transfer,
// with position, background weight, on-screen flag and last-pixel flag.
// A start emits the first endpoint; each advance emits one pixel, or a straddling
// pair (two transfers) on x-major and y-major lines, which end with the exact endpoint.
// An advance with no line in progress produces no transfer.
// Flow: the input is taken only while the controller is idle. An advance goes from
// the decode state to the step state, which loads its pixel into the output register
// once it is free, then to the pair state for a pair; the next item is taken once the
// controller is idle again. A horizontal, vertical, diagonal or single-point start goes
// from decode to loading the first endpoint; a major-axis start first runs the restoring
// divider one quotient bit per cycle. The output register holds a result while out_stall
// is high; the controller waits before loading the next pixel, so nothing is dropped and
// the input stays stalled. The visible column and row counts (registers 0 and 1) are
// written through cfg_write; the user must do so only while idle; the block does not check it.
// Reset: no line in progress, output empty, screen size 640 x 480.
module wu_antialiased_line_rasterizer_core #(
    parameter int COORD_BITS    = 12,
    parameter int FRACTION_BITS = 16,
    parameter int WEIGHT_BITS   = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [wal_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [wal_pkg::CFG_BITS-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic signed [COORD_BITS-1:0]        x_start,
    input  logic signed [COORD_BITS-1:0]        y_start,
    input  logic signed [COORD_BITS-1:0]        x_end,
    input  logic signed [COORD_BITS-1:0]        y_end,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [COORD_BITS:0]          pixel_x,
    output logic signed [COORD_BITS:0]          pixel_y,
    output logic [WEIGHT_BITS-1:0]              background_weight,
    output logic                                on_screen,
    output logic                                line_done
);
    import wal_pkg::*;

    wal_cmd_t    cmd;
    wal_status_t status;

    wal_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    wal_dp #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .WEIGHT_BITS   (WEIGHT_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mode              (mode),
        .x_start           (x_start),
        .y_start           (y_start),
        .x_end             (x_end),
        .y_end             (y_end),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .pixel_x           (pixel_x),
        .pixel_y           (pixel_y),
        .background_weight (background_weight),
        .on_screen         (on_screen),
        .line_done         (line_done)
    );

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wal_pkg::*;

    localparam int COORD_BITS      = 12;
    localparam int FRACTION_BITS   = 16;
    localparam int WEIGHT_BITS     = 8;
    localparam int SETTLE_CYCLES   = 40;
    localparam int END_CYCLES      = 40;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int PHASES          = 6;
    localparam int PHASE_ITEMS     = 115;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // -1 picks a random size for that phase
    localparam int PHASE_W[PHASES]   = '{2048, 1, 0, 4095, -1, 640};
    localparam int PHASE_H[PHASES]   = '{2048, 1, 4095, 0, -1, 480};
    localparam int PHASE_PCT[PHASES] = '{25, 0, 40, 10, 30, 0};

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COORD_BITS:0]   pos_t;
    typedef logic [COORD_BITS-1:0]        count_t;
    typedef logic [FRACTION_BITS-1:0]     frac_t;
    typedef logic [WEIGHT_BITS-1:0]       weight_t;

    localparam weight_t FULL_WEIGHT = '1;

    typedef enum logic [1:0] {
        ACT_ITEM,
        ACT_DRAIN,
        ACT_WRITE
    } act_t;

    typedef struct {
        act_t                      act;
        logic                      mode;
        coord_t                    xs;
        coord_t                    ys;
        coord_t                    xe;
        coord_t                    ye;
        logic [CFG_INDEX_BITS-1:0] reg_idx;
        logic [CFG_BITS-1:0]       reg_data;
        int                        idle_pct;
    } stim_t;

    typedef struct {
        pos_t    x;
        pos_t    y;
        weight_t w;
        logic    vis;
        logic    done;
    } pixel_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]       cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic                      mode      = 1'b0;
    coord_t                    x_start   = '0;
    coord_t                    y_start   = '0;
    coord_t                    x_end     = '0;
    coord_t                    y_end     = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    pos_t                      pixel_x;
    pos_t                      pixel_y;
    weight_t                   background_weight;
    logic                      on_screen;
    logic                      line_done;

    stim_t  stim_q[$];
    pixel_t pixels_due[$];

    // line tracer state
    logic [CFG_BITS-1:0] scr_w      = VIEW_COLS_RESET;
    logic [CFG_BITS-1:0] scr_h      = VIEW_ROWS_RESET;
    pos_t                pos_x      = '0;
    pos_t                pos_y      = '0;
    pos_t                end_x      = '0;
    pos_t                end_y      = '0;
    logic                go_left    = 1'b0;
    logic                drawing    = 1'b0;
    logic                tail_due   = 1'b0;
    count_t              steps_left = '0;
    frac_t               err_inc    = '0;
    frac_t               err_acc    = '0;
    line_kind_t          kind       = KIND_POINT;

    logic in_xfer        = 1'b0;
    logic timed_out      = 1'b0;
    int   errors         = 0;
    int   quiet_cycles   = 0;
    int   settled_cycles = 0;
    int   hold_left      = 0;
    int   stall_left     = 0;
    int   settle_cnt     = 0;
    int   cur_pct        = 0;
    int   gen_pct        = 0;

    wu_antialiased_line_rasterizer_core #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .WEIGHT_BITS   (WEIGHT_BITS)
    ) dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void plot(int x, int y, weight_t w, logic done);
        pixel_t p;
        p.x    = pos_t'(x);
        p.y    = pos_t'(y);
        p.w    = w;
        p.done = done;
        p.vis  = x >= 0 && y >= 0 && x < int'(scr_w) && y < int'(scr_h);
        pixels_due.push_back(p);
    endfunction

    // Expected pixels for one accepted transfer.
    function automatic void trace_line(logic m, coord_t xs, coord_t ys, coord_t xe, coord_t ye);
        int      x0;
        int      y0;
        int      x1;
        int      y1;
        int      dx;
        int      dy;
        int      swap;
        int      xdir;
        frac_t   prev;
        weight_t wt;
        if (m == MODE_START)
        begin
            x0 = xs;
            y0 = ys;
            x1 = xe;
            y1 = ye;
            if (y0 > y1)
            begin
                swap = y0;
                y0   = y1;
                y1   = swap;
                swap = x0;
                x0   = x1;
                x1   = swap;
            end
            dx      = x1 - x0;
            go_left = dx < 0;
            if (dx < 0)
                dx = -dx;
            dy       = y1 - y0;
            pos_x    = pos_t'(x0);
            pos_y    = pos_t'(y0);
            end_x    = pos_t'(x1);
            end_y    = pos_t'(y1);
            err_acc  = '0;
            err_inc  = '0;
            tail_due = 1'b0;
            drawing  = 1'b1;
            if (dy == 0)
            begin
                kind       = (dx == 0) ? KIND_POINT : KIND_HORIZ;
                steps_left = count_t'(dx);
            end
            else if (dx == 0)
            begin
                kind       = KIND_VERT;
                steps_left = count_t'(dy);
            end
            else if (dx == dy)
            begin
                kind       = KIND_DIAG;
                steps_left = count_t'(dy);
            end
            else if (dy > dx)
            begin
                kind       = KIND_YMAJ;
                err_inc    = frac_t'((dx << FRACTION_BITS) / dy);
                steps_left = count_t'(dy - 1);
            end
            else
            begin
                kind       = KIND_XMAJ;
                err_inc    = frac_t'((dy << FRACTION_BITS) / dx);
                steps_left = count_t'(dx - 1);
            end
            if (kind == KIND_POINT)
            begin
                drawing = 1'b0;
                plot(x0, y0, '0, 1'b1);
            end
            else
            begin
                if (kind >= KIND_YMAJ && steps_left == '0)
                    tail_due = 1'b1;
                plot(x0, y0, '0, 1'b0);
            end
        end
        else if (drawing)
        begin
            xdir = go_left ? -1 : 1;
            if (kind >= KIND_YMAJ)
            begin
                if (tail_due || steps_left == '0)
                begin
                    drawing  = 1'b0;
                    tail_due = 1'b0;
                    pos_x    = end_x;
                    pos_y    = end_y;
                    plot(end_x, end_y, '0, 1'b1);
                end
                else
                begin
                    prev    = err_acc;
                    err_acc = err_acc + err_inc;
                    wt      = err_acc[FRACTION_BITS-1 -: WEIGHT_BITS];
                    // wrap of the error sum moves the minor axis
                    if (kind == KIND_YMAJ)
                    begin
                        if (err_acc <= prev)
                            pos_x = pos_t'(pos_x + xdir);
                        pos_y = pos_t'(pos_y + 1);
                        plot(pos_x, pos_y, wt, 1'b0);
                        plot(pos_x + xdir, pos_y, wt ^ FULL_WEIGHT, 1'b0);
                    end
                    else
                    begin
                        if (err_acc <= prev)
                            pos_y = pos_t'(pos_y + 1);
                        pos_x = pos_t'(pos_x + xdir);
                        plot(pos_x, pos_y, wt, 1'b0);
                        plot(pos_x, pos_y + 1, wt ^ FULL_WEIGHT, 1'b0);
                    end
                    steps_left = steps_left - 1'b1;
                    if (steps_left == '0)
                        tail_due = 1'b1;
                end
            end
            else
            begin
                if (kind != KIND_VERT)
                    pos_x = pos_t'(pos_x + xdir);
                if (kind != KIND_HORIZ)
                    pos_y = pos_t'(pos_y + 1);
                if (steps_left != '0)
                    steps_left = steps_left - 1'b1;
                if (steps_left == '0)
                    drawing = 1'b0;
                plot(pos_x, pos_y, '0, steps_left == '0);
            end
        end
    endfunction

    function automatic void check_field(string name, int want_v, int got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            errors++;
        end
    endfunction

    // monitor: input transfers feed the tracer, output transfers are checked
    always @(posedge clk)
    begin
        pixel_t want;
        logic   out_xfer;
        if (rst_n)
        begin
            in_xfer  = in_valid && !in_stall;
            out_xfer = out_valid && !out_stall;
            if (in_xfer)
                trace_line(mode, x_start, y_start, x_end, y_end);
            if (out_xfer)
            begin
                if (pixels_due.size() == 0)
                begin
                    $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d weight=%0d",
                             $time, pixel_x, pixel_y, background_weight);
                    errors++;
                end
                else
                begin
                    want = pixels_due.pop_front();
                    check_field("pixel_x", want.x, pixel_x);
                    check_field("pixel_y", want.y, pixel_y);
                    check_field("background_weight", want.w, background_weight);
                    check_field("on_screen", want.vis, on_screen);
                    check_field("line_done", want.done, line_done);
                end
            end
            quiet_cycles = (in_xfer || out_xfer) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_CYCLES)
                timed_out = 1'b1;
            if (stim_q.size() == 0 && !in_valid && pixels_due.size() == 0)
                settled_cycles++;
            else
                settled_cycles = 0;
        end
    end

    // driver: inputs and out_stall change on the falling edge
    always @(negedge clk)
    begin
        stim_t head;
        logic  v;
        logic  wr;
        logic  st;
        if (rst_n)
        begin
            v  = in_valid && !in_xfer;
            wr = 1'b0;
            if (stall_left > 0)
            begin
                stall_left--;
                st = 1'b1;
            end
            else if ($urandom_range(99) < cur_pct)
            begin
                stall_left = $urandom_range(0, 6);
                st         = 1'b1;
            end
            else
                st = 1'b0;
            if (!v && stim_q.size() > 0)
            begin
                head = stim_q[0];
                case (head.act)
                    ACT_ITEM:
                    begin
                        cur_pct = head.idle_pct;
                        if (hold_left == 0 && $urandom_range(99) < head.idle_pct)
                            hold_left = $urandom_range(1, 7);
                        if (hold_left > 0)
                            hold_left--;
                        else
                        begin
                            stim_q.delete(0);
                            mode    <= head.mode;
                            x_start <= head.xs;
                            y_start <= head.ys;
                            x_end   <= head.xe;
                            y_end   <= head.ye;
                            v = 1'b1;
                        end
                    end
                    ACT_DRAIN:
                    begin
                        if (pixels_due.size() == 0)
                            stim_q.delete(0);
                    end
                    ACT_WRITE:
                    begin
                        // an ignored advance may still be in flight, so wait it out
                        if (pixels_due.size() != 0)
                            settle_cnt = 0;
                        else if (settle_cnt < SETTLE_CYCLES)
                            settle_cnt++;
                        else
                        begin
                            wr = 1'b1;
                            cfg_index <= head.reg_idx;
                            cfg_data  <= head.reg_data;
                            if (head.reg_idx == REG_VIEW_COLS)
                                scr_w = head.reg_data;
                            else
                                scr_h = head.reg_data;
                            settle_cnt = 0;
                            stim_q.delete(0);
                        end
                    end
                    default:
                        stim_q.delete(0);
                endcase
            end
            in_valid  <= v;
            cfg_write <= wr;
            out_stall <= st;
        end
    end

    function automatic void push_item(logic m, int xs, int ys, int xe, int ye);
        stim_t s;
        s.act      = ACT_ITEM;
        s.mode     = m;
        s.xs       = coord_t'(xs);
        s.ys       = coord_t'(ys);
        s.xe       = coord_t'(xe);
        s.ye       = coord_t'(ye);
        s.reg_idx  = '0;
        s.reg_data = '0;
        s.idle_pct = gen_pct;
        stim_q.push_back(s);
    endfunction

    function automatic void push_control(act_t a, logic [CFG_INDEX_BITS-1:0] idx, int data);
        stim_t s;
        s.act      = a;
        s.mode     = MODE_ADVANCE;
        s.xs       = '0;
        s.ys       = '0;
        s.xe       = '0;
        s.ye       = '0;
        s.reg_idx  = idx;
        s.reg_data = CFG_BITS'(data);
        s.idle_pct = gen_pct;
        stim_q.push_back(s);
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(4095)) - 2048;
    endfunction

    function automatic int fit_coord(int v);
        if (v < -2048)
            return -2048;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    function automatic int near_border(int limit);
        case ($urandom_range(3))
            0:       return int'($urandom_range(12)) - 6;
            1:       return fit_coord(limit + int'($urandom_range(12)) - 6);
            default: return int'($urandom_range(4079)) - 2040;
        endcase
    endfunction

    // advances carry random endpoint fields, which the block ignores
    function automatic void push_advances(int n);
        for (int i = 0; i < n; i++)
            push_item(MODE_ADVANCE, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endfunction

    // One start plus its advances; returns the count of transfers that do work.
    function automatic int queue_line(int lim_w, int lim_h);
        int   ax;
        int   ay;
        int   bx;
        int   by;
        int   d;
        int   span;
        int   reach;
        int   n_adv;
        int   r;
        logic wide;
        wide = $urandom_range(19) == 0;
        if (wide)
        begin
            ax = rand_coord();
            ay = rand_coord();
            bx = rand_coord();
            by = rand_coord();
        end
        else
        begin
            span = ($urandom_range(3) == 0) ? 40 : 8;
            ax   = near_border(lim_w);
            ay   = near_border(lim_h);
            bx   = ax + int'($urandom_range(2 * span)) - span;
            by   = ay + int'($urandom_range(2 * span)) - span;
            case ($urandom_range(5))
                0:       by = ay;
                1:       bx = ax;
                2:
                begin
                    d = by - ay;
                    if (d < 0)
                        d = -d;
                    bx = (bx < ax) ? ax - d : ax + d;
                end
                default: ;
            endcase
            bx = fit_coord(bx);
            by = fit_coord(by);
        end
        reach = (bx > ax) ? bx - ax : ax - bx;
        d     = (by > ay) ? by - ay : ay - by;
        if (d > reach)
            reach = d;
        r = $urandom_range(9);
        if (wide)
            n_adv = $urandom_range(0, 6);
        else if (r < 7)
            n_adv = reach;
        else if (r < 9)
            n_adv = $urandom_range(0, reach);
        else
            n_adv = reach + int'($urandom_range(1, 2));
        push_item(MODE_START, ax, ay, bx, by);
        push_advances(n_adv);
        return 1 + ((n_adv < reach) ? n_adv : reach);
    endfunction

    initial
    begin
        int w;
        int h;
        int made;
        gen_pct = 20;
        // point line, then an advance with nothing in progress
        push_item(MODE_START, 0, 0, 0, 0);
        push_advances(1);
        push_item(MODE_START, 5, 3, 1, 3);
        push_advances(4);
        // vertical, endpoints swapped, rows below zero
        push_item(MODE_START, 2, 1, 2, -1);
        push_advances(2);
        push_item(MODE_START, 3, 4, 0, 1);
        push_advances(3);
        push_item(MODE_START, 0, 0, 1, 3);
        push_advances(3);
        // x-major across the screen corner, abandoned by the next start
        push_item(MODE_START, 639, 479, 645, 481);
        push_advances(1);
        push_item(MODE_START, -2048, -2048, 2047, 2047);
        push_advances(1);
        push_item(MODE_START, -2048, 2047, 2047, -2048);
        push_advances(1);
        push_item(MODE_START, 2047, 0, -2048, 1);
        push_advances(1);
        push_control(ACT_DRAIN, '0, 0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            w = (PHASE_W[ph] < 0) ? int'($urandom_range(1, 2048)) : PHASE_W[ph];
            h = (PHASE_H[ph] < 0) ? int'($urandom_range(1, 2048)) : PHASE_H[ph];
            push_control(ACT_WRITE, REG_VIEW_COLS, w);
            push_control(ACT_WRITE, REG_VIEW_ROWS, h);
            gen_pct = PHASE_PCT[ph];
            made    = 0;
            while (made < PHASE_ITEMS)
            begin
                if ($urandom_range(11) == 0)
                    push_control(ACT_DRAIN, '0, 0);
                made += queue_line(w, h);
            end
        end

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        while (!timed_out && settled_cycles < END_CYCLES)
            @(negedge clk);
        if (timed_out)
            $display("%0t: no transfer for %0d cycles, watchdog expired", $time, WATCHDOG_CYCLES);
        if (!timed_out && errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/wal_pkg.sv
sv/wal_ctrl.sv
sv/wal_dp.sv
sv/wu_antialiased_line_rasterizer_core.sv
sim/tb.sv
